FILE: sv/gfalu_pkg.sv
`default_nettype none
package gfalu_pkg;

  localparam int ELEM_W = 131;
  localparam int DEG_W  = 8;

  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_MUL = 2'd1;
  localparam logic [1:0] FUNC_SQR = 2'd2;
  localparam logic [1:0] FUNC_INV = 2'd3;

  // Low terms of the reduction polynomial: x^13 + x^2 + x + 1.
  localparam logic [ELEM_W-1:0] RED_LOW = ELEM_W'(14'h2007);
  // Full polynomial f with its x^131 term.
  localparam logic [ELEM_W:0]   POLY    = {1'b1, RED_LOW};

  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [ELEM_W:0]   wide_t;
  typedef logic [DEG_W-1:0]  deg_t;

  // Multiply by x and reduce mod f.
  function automatic elem_t dbl_mod(elem_t t);
    elem_t s;
    s = {t[ELEM_W-2:0], 1'b0};
    if (t[ELEM_W-1]) begin
      s = s ^ RED_LOW;
    end
    return s;
  endfunction

  // Divide by x mod f: add f first when the constant term is set.
  function automatic elem_t half_mod(elem_t g);
    wide_t w;
    w = {1'b0, g};
    if (g[0]) begin
      w = w ^ POLY;
    end
    return w[ELEM_W:1];
  endfunction

endpackage
`default_nettype wire

FILE: sv/gf2_131_field_alu_unit.sv
`default_nettype none
// GF(2^131) arithmetic unit over f = x^131 + x^13 + x^2 + x + 1. One request carries
// an operation code and two reduced operands split into 64, 64 and 3 bit words; it
// yields one reduced element and a div_zero flag that is set only when the inverse
// of zero is asked for, in which case the result is zero. The block works on one
// request at a time and stalls its input while busy, but a finished result waits in
// an output register, so the next request can be taken before that result is read.
// Multiply and square run 131 shift-and-add steps of one shared doubling unit, one
// coefficient of a per cycle, plus entry and exit. Inverse runs the right-shift
// binary Euclidean algorithm, one divide-by-x, degree update or add per cycle,
// plus entry and exit. A result that is done while the output register is still
// full waits in place until the register is read.
module gf2_131_field_alu_unit
  import gfalu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  func,
  input  wire logic [63:0] a_word0,
  input  wire logic [63:0] a_word1,
  input  wire logic [2:0]  a_word2,
  input  wire logic [63:0] b_word0,
  input  wire logic [63:0] b_word1,
  input  wire logic [2:0]  b_word2,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      r_word0,
  output logic [63:0]      r_word1,
  output logic [2:0]       r_word2,
  output logic             div_zero
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_INV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam deg_t LAST_STEP = deg_t'(ELEM_W - 1);
  localparam deg_t DEG_A0    = deg_t'(ELEM_W - 1);
  localparam deg_t DEG_F     = deg_t'(ELEM_W);

  // During a multiply, u shifts the coefficients of a out at bit 0, g1 is the
  // accumulator and g2 the running b * x^i, or a * x^i for a square. During an
  // inverse the same registers hold the Euclidean pair (u, v) and their cofactors
  // (g1, g2), with g1*a = u and g2*a = v mod f. du and dv bound the degrees of u, v.
  logic [1:0] state, state_next;
  wide_t      u, u_next;
  wide_t      v, v_next;
  elem_t      g1, g1_next;
  elem_t      g2, g2_next;
  deg_t       du, du_next;
  deg_t       dv, dv_next;
  deg_t       cnt, cnt_next;
  logic       dz, dz_next;

  elem_t      r;
  logic       out_free;
  logic       in_take;
  elem_t      a_in, b_in;

  assign a_in     = {a_word2, a_word1, a_word0};
  assign b_in     = {b_word2, b_word1, b_word0};
  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    u_next     = u;
    v_next     = v;
    g1_next    = g1;
    g2_next    = g2;
    du_next    = du;
    dv_next    = dv;
    cnt_next   = cnt;
    dz_next    = dz;
    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          dz_next  = 1'b0;
          cnt_next = '0;
          unique case (func)
            FUNC_ADD: begin
              g1_next    = a_in ^ b_in;
              state_next = ST_DONE;
            end
            FUNC_MUL, FUNC_SQR: begin
              u_next     = {1'b0, a_in};
              g1_next    = '0;
              g2_next    = (func == FUNC_MUL) ? b_in : a_in;
              state_next = ST_MUL;
            end
            default: begin
              if (a_in == '0) begin
                g1_next    = '0;
                dz_next    = 1'b1;
                state_next = ST_DONE;
              end else begin
                u_next     = {1'b0, a_in};
                v_next     = POLY;
                g1_next    = ELEM_W'(1);
                g2_next    = '0;
                du_next    = DEG_A0;
                dv_next    = DEG_F;
                state_next = ST_INV;
              end
            end
          endcase
        end
      end
      ST_MUL: begin
        if (u[0]) begin
          g1_next = g1 ^ g2;
        end
        g2_next  = dbl_mod(g2);
        u_next   = u >> 1;
        cnt_next = cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          state_next = ST_DONE;
        end
      end
      ST_INV: begin
        priority if (u == wide_t'(1)) begin
          state_next = ST_DONE;
        end else if (v == wide_t'(1)) begin
          g1_next    = g2;
          state_next = ST_DONE;
        end else if (!u[0]) begin
          u_next  = u >> 1;
          g1_next = half_mod(g1);
          du_next = du - 1'b1;
        end else if (!v[0]) begin
          v_next  = v >> 1;
          g2_next = half_mod(g2);
          dv_next = dv - 1'b1;
        end else if (!u[du]) begin
          du_next = du - 1'b1;
        end else if (!v[dv]) begin
          dv_next = dv - 1'b1;
        end else if (du > dv) begin
          // Degrees are exact here, so u keeps its degree.
          u_next  = u ^ v;
          g1_next = g1 ^ g2;
        end else begin
          v_next  = v ^ u;
          g2_next = g2 ^ g1;
        end
      end
      default: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    u   <= u_next;
    v   <= v_next;
    g1  <= g1_next;
    g2  <= g2_next;
    du  <= du_next;
    dv  <= dv_next;
    cnt <= cnt_next;
    dz  <= dz_next;
    if (state == ST_DONE && out_free) begin
      r        <= g1;
      div_zero <= dz;
    end
  end

  assign r_word0 = r[63:0];
  assign r_word1 = r[127:64];
  assign r_word2 = r[ELEM_W-1:128];

endmodule
`default_nettype wire
